// ===== rtl/bcs_pkg.sv =====
// Shared types and constants for the binary content sniffer.
// Verdict codes, header byte array type and the signature byte values.
// No dependencies.
package bcs_pkg;

  localparam int unsigned HdrLen = 12;
  localparam int unsigned PosW   = 13;

  localparam logic [PosW-1:0] POS_MAX = 13'd8191;
  localparam logic [PosW-1:0] SIG_MIN_LEN  = 13'd8;
  localparam logic [PosW-1:0] WEBP_MIN_LEN = 13'd12;

  localparam logic [7:0] NULL_LIMIT_RST = 8'd5;

  // Control byte classification
  localparam logic [7:0] CTRL_LIMIT = 8'd32;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_NUL    = 8'h00;

  // Signature bytes
  localparam logic [7:0] PNG_LEAD = 8'h89;
  localparam logic [7:0] JPG_FF   = 8'hFF;
  localparam logic [7:0] JPG_D8   = 8'hD8;
  localparam logic [7:0] CHR_UP_P = 8'h50;
  localparam logic [7:0] CHR_UP_N = 8'h4E;
  localparam logic [7:0] CHR_UP_G = 8'h47;
  localparam logic [7:0] CHR_UP_I = 8'h49;
  localparam logic [7:0] CHR_UP_F = 8'h46;
  localparam logic [7:0] CHR_UP_R = 8'h52;
  localparam logic [7:0] CHR_UP_W = 8'h57;
  localparam logic [7:0] CHR_UP_E = 8'h45;
  localparam logic [7:0] CHR_UP_B = 8'h42;
  localparam logic [7:0] CHR_UP_M = 8'h4D;
  localparam logic [7:0] CHR_8    = 8'h38;
  localparam logic [7:0] CHR_7    = 8'h37;
  localparam logic [7:0] CHR_9    = 8'h39;
  localparam logic [7:0] CHR_LO_A = 8'h61;

  typedef enum logic [2:0] {
    VERDICT_TEXT = 3'd0,
    VERDICT_PNG  = 3'd1,
    VERDICT_JPEG = 3'd2,
    VERDICT_GIF  = 3'd3,
    VERDICT_WEBP = 3'd4,
    VERDICT_BMP  = 3'd5,
    VERDICT_HEUR = 3'd6
  } verdict_e;

  typedef logic [HdrLen-1:0][7:0] hdr_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

endpackage

// ===== rtl/bcs_channels.sv =====
// Valid/ready channel interfaces of the binary content sniffer.
// Input byte channel, verdict channel and configuration write channel.
// No dependencies.
interface bcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bcs_out_if;
  logic       valid;
  logic       ready;
  logic       is_binary;
  logic [2:0] verdict;

  modport source (output valid, output is_binary, output verdict, input ready);
  modport sink   (input valid, input is_binary, input verdict, output ready);
endinterface

interface bcs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bcs_in_reg.sv =====
// Input register of the binary content sniffer.
// Depends on bcs_pkg and bcs_in_if.
module bcs_in_reg
  import bcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bcs_in_if.sink     in_i,
  input  logic       adv_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_i.ready = !valid_q || adv_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.data_byte <= in_i.data_byte;
      item_q.last_byte <= in_i.last_byte;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/bcs_sig_match.sv =====
// File signature matcher: tests the header bytes in priority order.
// Depends on bcs_pkg.
module bcs_sig_match
  import bcs_pkg::*;
(
  input  hdr_t     hdr_i,
  input  logic     ge8_i,
  input  logic     ge12_i,
  output verdict_e sig_o
);

  logic is_png, is_jpg, is_gif, is_webp, is_bmp;

  always_comb begin
    is_png  = hdr_i[0] == PNG_LEAD && hdr_i[1] == CHR_UP_P &&
              hdr_i[2] == CHR_UP_N && hdr_i[3] == CHR_UP_G;
    is_jpg  = hdr_i[0] == JPG_FF && hdr_i[1] == JPG_D8 && hdr_i[2] == JPG_FF;
    is_gif  = hdr_i[0] == CHR_UP_G && hdr_i[1] == CHR_UP_I &&
              hdr_i[2] == CHR_UP_F && hdr_i[3] == CHR_8 &&
              (hdr_i[4] == CHR_7 || hdr_i[4] == CHR_9) && hdr_i[5] == CHR_LO_A;
    // RIFF container only counts once the WEBP tag bytes are in
    is_webp = ge12_i &&
              hdr_i[0] == CHR_UP_R && hdr_i[1] == CHR_UP_I &&
              hdr_i[2] == CHR_UP_F && hdr_i[3] == CHR_UP_F &&
              hdr_i[8] == CHR_UP_W && hdr_i[9] == CHR_UP_E &&
              hdr_i[10] == CHR_UP_B && hdr_i[11] == CHR_UP_P;
    is_bmp  = hdr_i[0] == CHR_UP_B && hdr_i[1] == CHR_UP_M;

    sig_o = VERDICT_TEXT;
    if (ge8_i) begin
      if (is_png) begin
        sig_o = VERDICT_PNG;
      end else if (is_jpg) begin
        sig_o = VERDICT_JPEG;
      end else if (is_gif) begin
        sig_o = VERDICT_GIF;
      end else if (is_webp) begin
        sig_o = VERDICT_WEBP;
      end else if (is_bmp) begin
        sig_o = VERDICT_BMP;
      end
    end
  end

endmodule

// ===== rtl/bcs_tracker.sv =====
// Per-stream state: byte position, header capture, zero and control counts,
// and the verdict for the final byte. Depends on bcs_pkg and bcs_sig_match.
module bcs_tracker
  import bcs_pkg::*;
#(
  parameter int unsigned WINDOW = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  item_t      item_i,
  input  logic [7:0] null_limit_i,
  output verdict_e   verdict_o
);

  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam logic [PosW-1:0] WinLen = PosW'(WINDOW);

  logic [PosW-1:0] pos_q, pos_d, pos_next, checked, quarter;
  logic [CntW-1:0] zero_q, zero_d, zero_next;
  logic [CntW-1:0] ctrl_q, ctrl_d, ctrl_next;
  hdr_t            hdr_q, hdr_d;
  logic            in_win, is_zero, is_ctrl, heur;
  verdict_e        sig;

  always_comb begin
    in_win  = pos_q < WinLen;
    is_zero = item_i.data_byte == CHR_NUL;
    is_ctrl = item_i.data_byte < CTRL_LIMIT &&
              !(item_i.data_byte inside {CHR_TAB, CHR_LF, CHR_CR});

    // Capture the byte into its header slot while the header is filling
    for (int i = 0; i < HdrLen; i++) begin
      hdr_d[i] = (pos_q == PosW'(i)) ? item_i.data_byte : hdr_q[i];
    end

    pos_next  = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
    zero_next = zero_q + CntW'(in_win && is_zero);
    ctrl_next = ctrl_q + CntW'(in_win && is_ctrl);

    checked = (pos_next < WinLen) ? pos_next : WinLen;
    quarter = checked >> 2;
    heur    = (PosW'(zero_next) > PosW'(null_limit_i)) ||
              (PosW'(ctrl_next) > quarter);

    verdict_o = sig;
    if (sig == VERDICT_TEXT && heur) begin
      verdict_o = VERDICT_HEUR;
    end

    // Drop all counts once the stream ends
    pos_d  = item_i.last_byte ? '0 : pos_next;
    zero_d = item_i.last_byte ? '0 : zero_next;
    ctrl_d = item_i.last_byte ? '0 : ctrl_next;
  end

  bcs_sig_match u_sig_match (
    .hdr_i  (hdr_d),
    .ge8_i  (pos_next >= SIG_MIN_LEN),
    .ge12_i (pos_next >= WEBP_MIN_LEN),
    .sig_o  (sig)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      zero_q <= '0;
      ctrl_q <= '0;
    end else if (en_i) begin
      pos_q  <= pos_d;
      zero_q <= zero_d;
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hdr_q <= hdr_d;
    end
  end

endmodule

// ===== rtl/binary_content_sniffer_core.sv =====
// Binary content sniffer: classifies a byte stream as image/binary or text.
//
// Channels:
//   in_i   - one stream byte per item (data_byte) with last_byte on the final one.
//   out_o  - one item per stream: is_binary and a verdict code (text, png, jpeg,
//            gif, webp, bmp, heuristic binary), issued for the final byte only.
//   cfg_i  - writes null_limit, the zero-byte count above which the stream is
//            binary. Always ready; write it only while no stream is in flight.
// Timing: a byte is registered at the input and processed there by the tracker,
//   which loads the verdict for a final byte into the output register, from which
//   the verdict is offered. One byte per cycle is sustained while no final byte
//   waits on a stalled out_o; the tracker update is the only per-byte loop.
// Stalls: while out_o is stalled, non-final bytes keep flowing; a final byte
//   waits in the input register until the pending verdict is taken.
// Reset: counters and valid flags clear, null_limit returns to 5. The header
//   capture is not reset; it is only read once the stream length covers it.
// Depends on bcs_pkg, bcs_channels, bcs_in_reg and bcs_tracker.
module binary_content_sniffer_core
  import bcs_pkg::*;
#(
  parameter int unsigned WINDOW = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bcs_in_if.sink   in_i,
  bcs_out_if.source out_o,
  bcs_cfg_if.sink  cfg_i
);

  logic [7:0] limit_q;
  logic       s1_valid, adv;
  item_t      s1_item;
  verdict_e   verdict, verdict_q;
  logic       out_valid_q, out_valid_d;

  // Configuration register: always accept writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= NULL_LIMIT_RST;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data;
    end
  end

  // Advance the registered byte unless it ends a stream and the result slot
  // is occupied by a verdict nobody is taking
  assign adv = s1_valid &&
               (!s1_item.last_byte || !out_valid_q || out_o.ready);

  bcs_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  bcs_tracker #(
    .WINDOW (WINDOW)
  ) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .item_i       (s1_item),
    .null_limit_i (limit_q),
    .verdict_o    (verdict)
  );

  // Result register: load on a final byte, clear when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && s1_item.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_item.last_byte) begin
      verdict_q <= verdict;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.verdict   = verdict_q;
  assign out_o.is_binary = verdict_q != VERDICT_TEXT;

endmodule
